[rtl/plde_pkg.sv]
// Shared types, anchor table and constants for the piecewise-linear date estimator.
`default_nettype none

package plde_pkg;

    localparam int UID_W       = 64;
    localparam int ANCHOR_ROWS = 51;
    // Widest anchor id (seven thousand million) needs 33 bits.
    localparam int ID_W        = 33;
    localparam int DATE_W      = 31;
    // Widest gap between neighbouring ids and widest date rise over one segment.
    localparam int SPAN_W      = 30;
    localparam int RISE_W      = 26;
    // Segment slope as a fixed-point reciprocal, scaled by two to the SPAN_W.
    localparam int RECIP_SHIFT = SPAN_W;
    localparam int RECIP_W     = 33;
    localparam int QUOT_W      = RISE_W + 1;
    localparam int PA_W        = SPAN_W + RECIP_W;
    localparam int PB_W        = SPAN_W + RISE_W;
    localparam int QS_W        = QUOT_W + SPAN_W;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [DATE_W-1:0]  date_t;
    typedef logic [SPAN_W-1:0]  span_t;
    typedef logic [RISE_W-1:0]  rise_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [1:0]         cls_t;

    // Request classes
    localparam cls_t CLS_ZERO  = 2'd0;
    localparam cls_t CLS_FIRST = 2'd1;
    localparam cls_t CLS_LAST  = 2'd2;
    localparam cls_t CLS_MID   = 2'd3;

    typedef struct packed {
        date_t  base;
        rise_t  rise;
        span_t  span;
        recip_t recip;
        span_t  delta;
    } seg_t;

    localparam id_t ANCHOR_ID [ANCHOR_ROWS] = '{
        33'd1000000,    33'd2768409,    33'd7679610,    33'd11538514,
        33'd15835244,   33'd23646077,   33'd38015510,   33'd44634663,
        33'd46145305,   33'd54845238,   33'd63263518,   33'd101260938,
        33'd103151531,  33'd109393468,  33'd112594714,  33'd116812045,
        33'd122600695,  33'd124872445,  33'd130029930,  33'd132670343,
        33'd141733941,  33'd152253017,  33'd157242073,  33'd171295414,
        33'd188758258,  33'd191317690,  33'd199570902,  33'd229882272,
        33'd234462946,  33'd253685473,  33'd293169835,  33'd315690368,
        33'd342781860,  33'd352940995,  33'd369669043,  33'd400169472,
        33'd616816630,  33'd700000000,  33'd800000000,  33'd900000000,
        33'd1000000000, 33'd1200000000, 33'd1400000000, 33'd1600000000,
        33'd1800000000, 33'd2000000000, 33'd3000000000, 33'd4000000000,
        33'd5000000000, 33'd6000000000, 33'd7000000000
    };

    localparam date_t ANCHOR_DATE [ANCHOR_ROWS] = '{
        31'd1380326400, 31'd1383264000, 31'd1388448000, 31'd1391212800,
        31'd1392940800, 31'd1393459200, 31'd1393632000, 31'd1399334400,
        31'd1400198400, 31'd1411257600, 31'd1414454400, 31'd1425600000,
        31'd1433376000, 31'd1439683200, 31'd1444176000, 31'd1448323200,
        31'd1450483200, 31'd1453248000, 31'd1457481600, 31'd1461283200,
        31'd1465344000, 31'd1466121600, 31'd1471046400, 31'd1474156800,
        31'd1476835200, 31'd1477267200, 31'd1481932800, 31'd1493856000,
        31'd1499472000, 31'd1504137600, 31'd1508025600, 31'd1526342400,
        31'd1529625600, 31'd1532563200, 31'd1538006400, 31'd1542326400,
        31'd1548720000, 31'd1556668800, 31'd1571184000, 31'd1585699200,
        31'd1600214400, 31'd1614556800, 31'd1625097600, 31'd1633046400,
        31'd1643673600, 31'd1656633600, 31'd1690848000, 31'd1719792000,
        31'd1748736000, 31'd1777680000, 31'd1806624000
    };

endpackage

`default_nettype wire

[rtl/plde_locate.sv]
// Segment search: classify the identifier, pick its bracketing segment, form the offset.
`default_nettype none

module plde_locate
    import plde_pkg::*;
#(
    parameter int ROWS = 51
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [UID_W-1:0] in_uid,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output seg_t                  out_seg
);

    localparam int SEGS = ROWS - 1;

    // Per-segment constants, worked out at elaboration
    id_t    seg_lo    [SEGS];
    date_t  seg_base  [SEGS];
    rise_t  seg_rise  [SEGS];
    span_t  seg_span  [SEGS];
    recip_t seg_recip [SEGS];

    for (genvar g = 0; g < SEGS; g++) begin : g_seg
        localparam logic [63:0] LO_ID = 64'(ANCHOR_ID[g]);
        localparam logic [63:0] HI_ID = 64'(ANCHOR_ID[g+1]);
        localparam logic [63:0] SPAN  = HI_ID - LO_ID;
        localparam logic [63:0] RISE  = 64'(ANCHOR_DATE[g+1]) - 64'(ANCHOR_DATE[g]);
        // Rounded up, so the quotient estimate is exact or one too large
        localparam logic [63:0] RECIP = (SPAN == 64'd0) ? 64'd0 :
            (((RISE << RECIP_SHIFT) + SPAN - 64'd1) / SPAN);
        assign seg_lo[g]    = ANCHOR_ID[g];
        assign seg_base[g]  = ANCHOR_DATE[g];
        assign seg_rise[g]  = RISE[RISE_W-1:0];
        assign seg_span[g]  = SPAN[SPAN_W-1:0];
        assign seg_recip[g] = RECIP[RECIP_W-1:0];
    end

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1: compare against every anchor in use
    id_t             uid1_reg;
    logic [SEGS-1:0] ge1_reg;
    cls_t            cls1_reg;
    logic [SEGS-1:0] ge1_next;
    cls_t            cls1_next;

    always_comb begin
        for (int i = 0; i < SEGS; i++) begin
            ge1_next[i] = (in_uid >= UID_W'(ANCHOR_ID[i]));
        end
        if (in_uid == '0) begin
            cls1_next = CLS_ZERO;
        end else if (in_uid <= UID_W'(ANCHOR_ID[0])) begin
            cls1_next = CLS_FIRST;
        end else if (in_uid >= UID_W'(ANCHOR_ID[ROWS-1])) begin
            cls1_next = CLS_LAST;
        end else begin
            cls1_next = CLS_MID;
        end
    end

    // Stage 2: thermometer to one-hot, then select segment constants
    logic [SEGS-1:0] sel;
    id_t    lo_next;
    date_t  base_next;
    rise_t  rise_next;
    span_t  span_next;
    recip_t recip_next;

    id_t    uid2_reg;
    id_t    lo2_reg;
    date_t  base2_reg;
    rise_t  rise2_reg;
    span_t  span2_reg;
    recip_t recip2_reg;

    always_comb begin
        for (int i = 0; i < SEGS; i++) begin
            if (i == SEGS - 1) begin
                sel[i] = ge1_reg[i];
            end else begin
                sel[i] = ge1_reg[i] & ~ge1_reg[i+1];
            end
        end
        lo_next    = '0;
        base_next  = '0;
        rise_next  = '0;
        span_next  = '0;
        recip_next = '0;
        for (int i = 0; i < SEGS; i++) begin
            if (sel[i]) begin
                lo_next    = lo_next    | seg_lo[i];
                base_next  = base_next  | seg_base[i];
                rise_next  = rise_next  | seg_rise[i];
                span_next  = span_next  | seg_span[i];
                recip_next = recip_next | seg_recip[i];
            end
        end
        // Clamped and zero requests: flat slope, zero offset
        if (cls1_reg != CLS_MID) begin
            lo_next    = uid1_reg;
            rise_next  = '0;
            span_next  = span_t'(1);
            recip_next = '0;
            case (cls1_reg)
                CLS_FIRST: base_next = ANCHOR_DATE[0];
                CLS_LAST:  base_next = ANCHOR_DATE[ROWS-1];
                default:   base_next = '0;
            endcase
        end
    end

    // Stage 3: offset into the segment
    id_t delta_full;
    assign delta_full = uid2_reg - lo2_reg;

    assign en3      = ~v3_reg | out_ready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            uid1_reg <= in_uid[ID_W-1:0];
            ge1_reg  <= ge1_next;
            cls1_reg <= cls1_next;
        end
        if (en2) begin
            uid2_reg   <= uid1_reg;
            lo2_reg    <= lo_next;
            base2_reg  <= base_next;
            rise2_reg  <= rise_next;
            span2_reg  <= span_next;
            recip2_reg <= recip_next;
        end
        if (en3) begin
            out_seg.base  <= base2_reg;
            out_seg.rise  <= rise2_reg;
            out_seg.span  <= span2_reg;
            out_seg.recip <= recip2_reg;
            out_seg.delta <= delta_full[SPAN_W-1:0];
        end
    end

    assign out_valid = v3_reg;

    a_mid_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && cls1_reg == CLS_MID) |-> $onehot(sel))
        else $error("interior request selects other than exactly one segment");

    a_delta_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (out_seg.delta < out_seg.span))
        else $error("segment offset reaches beyond its span");

endmodule

`default_nettype wire

[rtl/plde_interp.sv]
// Interpolation: reciprocal multiply, one-step quotient correction, date add.
`default_nettype none

module plde_interp
    import plde_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire seg_t  in_seg,
    output logic       out_valid,
    input  wire logic  out_ready,
    output date_t      out_est_date
);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1 products
    logic [PA_W-1:0] pa1_reg;
    logic [PB_W-1:0] pb1_reg;
    span_t           span1_reg;
    date_t           base1_reg;

    // Stage 2 estimate and back-multiply
    logic [QUOT_W-1:0] qest_next;
    logic [QUOT_W-1:0] qest2_reg;
    logic [QS_W-1:0]   qs2_reg;
    logic [PB_W-1:0]   pb2_reg;
    span_t             span2_reg;
    date_t             base2_reg;

    // Stage 3 correction
    logic [QUOT_W-1:0] quot;
    date_t             est_next;

    assign qest_next = pa1_reg[RECIP_SHIFT +: QUOT_W];

    always_comb begin
        if (qs2_reg > QS_W'(pb2_reg)) begin
            quot = qest2_reg - QUOT_W'(1);
        end else begin
            quot = qest2_reg;
        end
        est_next = base2_reg + DATE_W'(quot);
    end

    assign en3      = ~v3_reg | out_ready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            pa1_reg   <= PA_W'(in_seg.delta) * PA_W'(in_seg.recip);
            pb1_reg   <= PB_W'(in_seg.delta) * PB_W'(in_seg.rise);
            span1_reg <= in_seg.span;
            base1_reg <= in_seg.base;
        end
        if (en2) begin
            qest2_reg <= qest_next;
            qs2_reg   <= QS_W'(qest_next) * QS_W'(span1_reg);
            pb2_reg   <= pb1_reg;
            span2_reg <= span1_reg;
            base2_reg <= base1_reg;
        end
        if (en3) begin
            out_est_date <= est_next;
        end
    end

    assign out_valid = v3_reg;

    a_one_step_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (qs2_reg <= QS_W'(pb2_reg) + QS_W'(span2_reg)))
        else $error("quotient estimate off by more than one");

    a_date_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (out_est_date <= ANCHOR_DATE[ANCHOR_ROWS-1]))
        else $error("estimate beyond the last anchor date");

endmodule

`default_nettype wire

[rtl/piecewise_linear_date_estimate.sv]
// Piecewise-linear date estimator: identifier in, interpolated date out, fully pipelined.
//
// Maps a 64-bit identifier to an estimated date in seconds since the epoch by linear
// interpolation over a fixed table of ascending (id, date) anchors. Zero gives 0;
// identifiers at or below the first anchor give the first date, at or above the last
// anchor in use the last date; anything between interpolates within its bracketing
// segment with the quotient truncated. One request is taken every clock unless a stall on
// m_ready has filled every stage; its result reaches m_valid through six register stages,
// the first loaded at the accepting edge: three of segment search (anchor compare, segment
// select, offset subtract) followed by three of interpolation (multiply by the segment's
// precomputed reciprocal slope, back-multiply, one-step correction and add). The slope
// division is replaced by a per-segment reciprocal rounded up, so the estimate is exact
// or one high and a single compare fixes it. Every stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall on m_ready holds
// results without loss and empty slots still fill from s_valid. NUM_ANCHORS selects how
// many table rows are used (clamped to two up to the table size). Reset clears only the
// valid bits; there is no other state.
`default_nettype none

module piecewise_linear_date_estimate
    import plde_pkg::*;
#(
    parameter int NUM_ANCHORS = 51
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [UID_W-1:0] s_user_id,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [DATE_W-1:0]     m_est_date
);

    // Rows in use, held to the table
    localparam int ROWS = (NUM_ANCHORS < 2) ? 2 :
                          ((NUM_ANCHORS > ANCHOR_ROWS) ? ANCHOR_ROWS : NUM_ANCHORS);

    logic seg_valid;
    logic seg_ready;
    seg_t seg;

    // Search: classify and pick the bracketing segment
    plde_locate #(
        .ROWS (ROWS)
    ) u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_uid    (s_user_id),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_seg   (seg)
    );

    // Interpolate within the segment and drive the result register
    plde_interp u_interp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (seg_valid),
        .in_ready     (seg_ready),
        .in_seg       (seg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_est_date (m_est_date)
    );

endmodule

`default_nettype wire
